// ===== src/ssm_pkg.sv =====
// shared types and constants for the stream substring matcher
// no dependencies
package ssm_pkg;

  // sizing
  localparam int MAX_PATTERN = 16;
  localparam int MAX_LINE    = 65536;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int PIDX_W      = $clog2(MAX_PATTERN);
  localparam int POS_W       = $clog2(MAX_LINE + 1);
  localparam int HIST_DEPTH  = MAX_PATTERN - 1;

  // fixed field widths of the result and configuration channels
  localparam int START_W = 16;
  localparam int END_W   = 17;
  localparam int COUNT_W = 17;
  localparam int CFG_LEN_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;

  // result queue
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LEN  = 2'd0,
    CFG_PAT_LOW  = 2'd1,
    CFG_PAT_HIGH = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  // result kinds
  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef logic [MAX_PATTERN-1:0][7:0] pat_t;

  typedef struct packed {
    kind_t              kind;
    logic [START_W-1:0] match_start;
    logic [END_W-1:0]   match_end;
    logic               passed;
    logic [COUNT_W-1:0] match_count;
    logic               overflow;
    logic               last_of_run;
  } res_t;

endpackage

// ===== src/ssm_match_core.sv =====
// window compare, line bookkeeping and result formation for one character
// depends on ssm_pkg
module ssm_match_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_vld,
  input  logic [7:0]                 item_char,
  input  logic                       item_last,
  input  logic [ssm_pkg::LEN_W-1:0]  act_len,
  input  ssm_pkg::pat_t              pat,
  output logic [1:0]                 push_cnt,
  output ssm_pkg::res_t              res0,
  output ssm_pkg::res_t              res1
);
  import ssm_pkg::*;

  localparam logic [POS_W-1:0]  LINE_LIM  = POS_W'(MAX_LINE);
  localparam logic [POS_W:0]    END_LIM   = (POS_W + 1)'(MAX_LINE);
  localparam logic [POS_W:0]    START_LIM = (POS_W + 1)'(MAX_LINE - 1);
  localparam logic [LEN_W-1:0]  PAT_LIM   = LEN_W'(MAX_PATTERN);

  logic [7:0]         hist_r [HIST_DEPTH];
  logic [LEN_W-1:0]   csr_r;
  logic [POS_W-1:0]   pos_r;
  logic [COUNT_W-1:0] found_r;
  logic               exceed_r;

  logic [7:0]         win [MAX_PATTERN];
  logic [PIDX_W-1:0]  pidx [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;
  logic [LEN_W-1:0]   csr_inc;
  logic               hit;
  logic               exceed_nxt;
  logic [COUNT_W-1:0] found_nxt;
  logic [POS_W:0]     end_full;
  logic [POS_W:0]     start_full;
  logic [POS_W:0]     end_sat;
  logic [POS_W:0]     start_sat;
  res_t               match_res;
  res_t               sum_res;

  // window with the new character in front
  always_comb begin
    win[0] = item_char;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win[i] = hist_r[i-1];
    end
  end

  // per position compare against the pattern, newest char vs last pattern byte
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pidx[i] = PIDX_W'(act_len - LEN_W'(i) - LEN_W'(1));
      if (LEN_W'(i) < act_len) begin
        eq[i] = (win[i] == pat[pidx[i]]);
      end else begin
        eq[i] = 1'b1;
      end
    end
  end

  // hit detection and offsets
  always_comb begin
    csr_inc    = (csr_r < PAT_LIM) ? csr_r + LEN_W'(1) : csr_r;
    hit        = (csr_inc >= act_len) && (&eq);
    exceed_nxt = exceed_r | (pos_r >= LINE_LIM);
    found_nxt  = (hit && (found_r < COUNT_W'(MAX_LINE))) ? found_r + COUNT_W'(1) : found_r;
    end_full   = {1'b0, pos_r} + (POS_W + 1)'(1);
    start_full = end_full - (POS_W + 1)'(act_len);
    end_sat    = (end_full > END_LIM) ? END_LIM : end_full;
    start_sat  = (start_full > START_LIM) ? START_LIM : start_full;
  end

  // result items
  always_comb begin
    match_res             = '0;
    match_res.kind        = KIND_MATCH;
    match_res.match_start = START_W'(start_sat);
    match_res.match_end   = END_W'(end_sat);
    match_res.last_of_run = ~item_last;

    sum_res               = '0;
    sum_res.kind          = KIND_SUMMARY;
    sum_res.passed        = (found_nxt != '0);
    sum_res.match_count   = found_nxt;
    sum_res.overflow      = exceed_nxt;
    sum_res.last_of_run   = 1'b1;

    res0     = hit ? match_res : sum_res;
    res1     = sum_res;
    push_cnt = item_vld ? (2'(hit) + 2'(item_last)) : 2'd0;
  end

  // character history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) hist_r[i] <= '0;
    end else if (item_vld) begin
      for (int i = 0; i < HIST_DEPTH; i++) hist_r[i] <= item_last ? 8'd0 : win[i];
    end
  end

  // per-line counters, cleared after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csr_r    <= '0;
      pos_r    <= '0;
      found_r  <= '0;
      exceed_r <= 1'b0;
    end else if (item_vld) begin
      if (item_last) begin
        csr_r    <= '0;
        pos_r    <= '0;
        found_r  <= '0;
        exceed_r <= 1'b0;
      end else begin
        csr_r    <= hit ? '0 : csr_inc;
        pos_r    <= (pos_r < LINE_LIM) ? pos_r + POS_W'(1) : pos_r;
        found_r  <= found_nxt;
        exceed_r <= exceed_nxt;
      end
    end
  end

  // checks
  a_csr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    csr_r <= PAT_LIM) else $error("resume count beyond pattern limit");
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && item_last |=> (pos_r == '0) && (found_r == '0) && !exceed_r)
    else $error("line state not cleared after line end");
  a_hit_resume: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && hit && !item_last |=> csr_r == '0)
    else $error("search did not resume after match");

endmodule

// ===== src/ssm_result_fifo.sv =====
// small result queue taking up to two results per cycle, one out per cycle when popped
// depends on ssm_pkg
module ssm_result_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  ssm_pkg::res_t push0,
  input  ssm_pkg::res_t push1,
  input  logic          pop,
  output logic          not_empty,
  output logic [ssm_pkg::RQ_AW:0] level,
  output ssm_pkg::res_t head
);
  import ssm_pkg::*;

  res_t             mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_r;
  logic [RQ_AW-1:0] rd_r;
  logic [RQ_AW:0]   cnt_r;
  logic [RQ_AW:0]   cnt_nxt;
  logic             do_pop;

  // occupancy
  always_comb begin
    do_pop    = pop && (cnt_r != '0);
    cnt_nxt   = cnt_r + (RQ_AW + 1)'(push_cnt) - (RQ_AW + 1)'(do_pop);
    not_empty = (cnt_r != '0);
    level     = cnt_r;
    head      = mem[rd_r];
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_r] <= push0;
    if (push_cnt == 2'd2) mem[wr_r + RQ_AW'(1)] <= push1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + RQ_AW'(push_cnt);
      rd_r  <= rd_r + RQ_AW'(do_pop);
      cnt_r <= cnt_nxt;
    end
  end

  // checks
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r + (RQ_AW + 1)'(push_cnt)) <= (RQ_AW + 1)'(RQ_DEPTH))
    else $error("result queue overrun");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    RQ_AW'(wr_r - rd_r) == RQ_AW'(cnt_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== src/stream_substring_matcher_core.sv =====
// top level of the stream substring matcher: config registers, input stage
// depends on ssm_pkg, ssm_match_core, ssm_result_fifo
//
// Usage: characters of one line arrive on the in_ channel, one per transfer,
// with in_line_end set on the final character. Every match of the configured
// pattern (1 to 16 bytes, non-overlapping, leftmost first) yields a match
// report with absolute start and end offsets; the final character is followed
// by a summary with pass flag, match count and overflow flag. last_of_run
// marks the final result caused by one character.
// A character is registered in the input stage at its transfer, and its
// results are then written from that stage into the result queue, whose
// head is offered on the out_ channel. Throughput: one character per cycle
// while in_stall is low; a character causes zero, one or two results, and
// the output side moves one result per cycle while out_stall is low, so lines
// with dense matches are limited by the out_ side.
// in_stall rises when the eight-entry result queue cannot take the results of
// one more character; out_stall holds the head result steady.
// Configuration: cfg_ready is always high; write only while the block is idle.
// Reset clears the line state, sets the pattern length to 1 and the pattern
// bytes to zero; the block takes characters as soon as reset is released.
module stream_substring_matcher_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_char_in,
  input  logic                          in_line_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [ssm_pkg::START_W-1:0]   out_match_start,
  output logic [ssm_pkg::END_W-1:0]     out_match_end,
  output logic                          out_passed,
  output logic [ssm_pkg::COUNT_W-1:0]   out_match_count,
  output logic                          out_overflow,
  output logic                          out_last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssm_pkg::*;

  localparam logic [LEN_W-1:0] PAT_LIM = LEN_W'(MAX_PATTERN);

  logic [CFG_LEN_W-1:0] len_r;
  pat_t                 pat_r;
  logic [LEN_W-1:0]     len_ext;
  logic [LEN_W-1:0]     act_len;

  logic                 stg_vld_r;
  logic [7:0]           stg_char_r;
  logic                 stg_last_r;
  logic                 in_xfer;
  logic                 cfg_xfer;

  logic [1:0]           push_cnt;
  res_t                 res0;
  res_t                 res1;
  res_t                 head;
  logic [RQ_AW:0]       level;
  logic                 q_not_empty;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= CFG_LEN_W'(1);
      pat_r <= '0;
    end else if (cfg_xfer) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_LEN: len_r <= cfg_data[CFG_LEN_W-1:0];
        CFG_PAT_LOW: begin
          for (int i = 0; i < 8; i++) begin
            if (i < MAX_PATTERN) pat_r[i] <= cfg_data[8*i +: 8];
          end
        end
        CFG_PAT_HIGH: begin
          for (int i = 0; i < 8; i++) begin
            if (i + 8 < MAX_PATTERN) pat_r[i+8] <= cfg_data[8*i +: 8];
          end
        end
        default: ;
      endcase
    end
  end

  // pattern length in use, zero taken as one, clamped to the maximum
  always_comb begin
    len_ext = LEN_W'(len_r);
    if (len_r == '0) begin
      act_len = LEN_W'(1);
    end else if (len_ext > PAT_LIM) begin
      act_len = PAT_LIM;
    end else begin
      act_len = len_ext;
    end
  end

  // input stage; room is kept for the staged item plus one more
  assign in_stall = (level + (stg_vld_r ? (RQ_AW + 1)'(2) : '0))
                    > (RQ_AW + 1)'(RQ_DEPTH - 2);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_char_r <= in_char_in;
      stg_last_r <= in_line_end;
    end
  end

  ssm_match_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (stg_vld_r),
    .item_char (stg_char_r),
    .item_last (stg_last_r),
    .act_len   (act_len),
    .pat       (pat_r),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  ssm_result_fifo u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .pop       (!out_stall),
    .not_empty (q_not_empty),
    .level     (level),
    .head      (head)
  );

  // result channel
  assign out_valid       = q_not_empty;
  assign out_kind        = head.kind;
  assign out_match_start = head.match_start;
  assign out_match_end   = head.match_end;
  assign out_passed      = head.passed;
  assign out_match_count = head.match_count;
  assign out_overflow    = head.overflow;
  assign out_last_of_run = head.last_of_run;

endmodule
